// ===== src/tbrl_pkg.sv =====
// Package for the token bucket rate limiter: shared types and constants.
`timescale 1ns / 1ps

package tbrl_pkg;

    // Field widths
    localparam int RATE_W    = 30;
    localparam int TOKEN_W   = 32;
    localparam int ELAPSED_W = 16;
    localparam int VERDICT_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // Request kinds on the input channel
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // Result verdicts
    localparam logic [VERDICT_W-1:0] VERDICT_GRANTED  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_REJECTED = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_BUSY     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

    // Reset values
    localparam logic [RATE_W-1:0]  RATE_RESET     = 30'd1000;
    localparam logic [TOKEN_W-1:0] CAPACITY_RESET = 32'd1000;

    // Milliseconds per second and the split of rate into rate/1000 and rate%1000
    localparam int MS_W      = 10;
    localparam int RATE_Q_W  = 21;
    localparam logic [MS_W-1:0] MS_PER_SECOND = 10'd1000;

    // Exact reciprocal of 1000 for 30-bit dividends: floor(x * M >> 40)
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 40;
    localparam logic [RECIP_W-1:0] RATE_RECIP = 31'd1099511628;
    localparam int RATE_PROD_W = RATE_W + RECIP_W;

    // Remainder part: elapsed * (rate % 1000) fits in 26 bits
    localparam int FRAC_W       = ELAPSED_W + MS_W;
    localparam int FRAC_RECIP_W = 27;
    localparam int FRAC_SHIFT   = 36;
    localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = 27'd68719477;
    localparam int FRAC_PROD_W  = FRAC_W + FRAC_RECIP_W;
    localparam int FRAC_Q_W     = FRAC_PROD_W - FRAC_SHIFT;

    // Whole part: elapsed * (rate / 1000)
    localparam int WHOLE_W = ELAPSED_W + RATE_Q_W;
    localparam int ADD_W   = WHOLE_W + 1;

    // Classified request handed from the front end to the token engine
    typedef struct packed {
        logic               mode;
        logic [TOKEN_W-1:0] add;   // refill amount, clamped to 32 bits
        logic [TOKEN_W-1:0] flow;
    } tbrl_item_t;

endpackage

// ===== src/tbrl_front.sv =====
// Front end: accepts requests, computes the tick refill amount, and issues credits.
`timescale 1ns / 1ps

module tbrl_front
    import tbrl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [ELAPSED_W-1:0] s_elapsed_ms,
    input  logic [TOKEN_W-1:0]   s_flow,
    input  logic                 q_pop,
    output logic                 q_push,
    output tbrl_item_t           q_item
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [RATE_W-1:0] rate_reg;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic              s_accept;

    // Stage 1: capture request, multiply rate by reciprocal of 1000
    logic                   v1_reg;
    logic                   mode1_reg;
    logic [ELAPSED_W-1:0]   elapsed1_reg;
    logic [TOKEN_W-1:0]     flow1_reg;
    logic [RATE_W-1:0]      rate1_reg;
    logic [RATE_PROD_W-1:0] rprod1_reg;

    // Stage 2: rate split into quotient and remainder
    logic                   v2_reg;
    logic                   mode2_reg;
    logic [ELAPSED_W-1:0]   elapsed2_reg;
    logic [TOKEN_W-1:0]     flow2_reg;
    logic [RATE_Q_W-1:0]    rq2_reg;
    logic [MS_W-1:0]        rr2_reg;

    // Stage 3: whole and fractional products
    logic                   v3_reg;
    logic                   mode3_reg;
    logic [TOKEN_W-1:0]     flow3_reg;
    logic [WHOLE_W-1:0]     whole3_reg;
    logic [FRAC_W-1:0]      frac3_reg;

    // Stage 4: fractional part divided by 1000
    logic                   v4_reg;
    logic                   mode4_reg;
    logic [TOKEN_W-1:0]     flow4_reg;
    logic [WHOLE_W-1:0]     whole4_reg;
    logic [FRAC_PROD_W-1:0] fprod4_reg;

    logic [RATE_Q_W-1:0]    rq;
    logic [RATE_W-1:0]      rq_x1000;
    logic [RATE_W-1:0]      rate_rem;
    logic [FRAC_Q_W-1:0]    frac_q;
    logic [ADD_W-1:0]       add_sum;

    assign s_ready  = (occ_reg < OCC_W'(QUEUE_DEPTH));
    assign s_accept = s_valid && s_ready;

    // Track requests in the pipeline plus the queue
    always_comb begin
        occ_next = occ_reg;
        if (s_accept && !q_pop) begin
            occ_next = occ_reg + 1'b1;
        end else if (!s_accept && q_pop) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg  <= '0;
            rate_reg <= RATE_RESET;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (cfg_wr_en && cfg_index == CFG_RATE) begin
                rate_reg <= cfg_wdata[RATE_W-1:0];
            end
            v1_reg <= s_accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Split rate: rq = rate / 1000, rr = rate % 1000
    assign rq       = rprod1_reg[RATE_PROD_W-1:RECIP_SHIFT];
    assign rq_x1000 = RATE_W'(rq) * RATE_W'(MS_PER_SECOND);
    assign rate_rem = rate1_reg - rq_x1000;

    // Refill = elapsed*rq + floor(elapsed*rr / 1000), clamp to token width
    assign frac_q  = fprod4_reg[FRAC_PROD_W-1:FRAC_SHIFT];
    assign add_sum = ADD_W'(whole4_reg) + ADD_W'(frac_q);

    // Advance the datapath every cycle
    always_ff @(posedge aclk) begin
        mode1_reg    <= s_mode;
        elapsed1_reg <= s_elapsed_ms;
        flow1_reg    <= s_flow;
        rate1_reg    <= rate_reg;
        rprod1_reg   <= RATE_PROD_W'(rate_reg) * RATE_PROD_W'(RATE_RECIP);

        mode2_reg    <= mode1_reg;
        elapsed2_reg <= elapsed1_reg;
        flow2_reg    <= flow1_reg;
        rq2_reg      <= rq;
        rr2_reg      <= rate_rem[MS_W-1:0];

        mode3_reg    <= mode2_reg;
        flow3_reg    <= flow2_reg;
        whole3_reg   <= WHOLE_W'(elapsed2_reg) * WHOLE_W'(rq2_reg);
        frac3_reg    <= FRAC_W'(elapsed2_reg) * FRAC_W'(rr2_reg);

        mode4_reg    <= mode3_reg;
        flow4_reg    <= flow3_reg;
        whole4_reg   <= whole3_reg;
        fprod4_reg   <= FRAC_PROD_W'(frac3_reg) * FRAC_PROD_W'(FRAC_RECIP);
    end

    assign q_push      = v4_reg;
    assign q_item.mode = mode4_reg;
    assign q_item.flow = flow4_reg;
    assign q_item.add  = (|add_sum[ADD_W-1:TOKEN_W]) ? '1 : add_sum[TOKEN_W-1:0];

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("front occupancy exceeds queue depth");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> v1_reg)
        else $error("accepted request missing from first stage");

endmodule

// ===== src/tbrl_fifo.sv =====
// Short queue between the front end and the token engine.
`timescale 1ns / 1ps

module tbrl_fifo
    import tbrl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  tbrl_item_t push_item,
    input  logic       pop,
    output logic       not_empty,
    output tbrl_item_t head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tbrl_item_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             full;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_item = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("queue underflow");

endmodule

// ===== src/tbrl_back.sv =====
// Token engine: holds the bucket and pending slot, produces verdicts.
`timescale 1ns / 1ps

module tbrl_back
    import tbrl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 q_valid,
    input  tbrl_item_t           q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VERDICT_W-1:0] m_verdict,
    output logic [TOKEN_W-1:0]   m_tokens_left
);

    logic [TOKEN_W-1:0]   capacity_reg, capacity_next;
    logic [TOKEN_W-1:0]   tokens_reg, tokens_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [TOKEN_W-1:0]   pend_flow_reg, pend_flow_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic [TOKEN_W-1:0]   left_reg, left_next;

    logic                 take;
    logic [TOKEN_W:0]     fill_sum;
    logic                 fill_sat;
    logic                 cap_cover, sum_cover, tick_cover;
    logic [TOKEN_W-1:0]   cap_rem, sum_rem, tick_fill;
    logic                 too_big, req_cover;
    logic [TOKEN_W-1:0]   req_rem;

    assign take = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = take;

    // Refill with saturation, and cover check of the held request on both paths
    assign fill_sum   = {1'b0, tokens_reg} + {1'b0, q_item.add};
    assign fill_sat   = fill_sum > {1'b0, capacity_reg};
    assign cap_cover  = capacity_reg >= pend_flow_reg;
    assign cap_rem    = capacity_reg - pend_flow_reg;
    assign sum_cover  = fill_sum >= {1'b0, pend_flow_reg};
    assign sum_rem    = fill_sum[TOKEN_W-1:0] - pend_flow_reg;
    assign tick_cover = fill_sat ? cap_cover : sum_cover;
    assign tick_fill  = fill_sat ? capacity_reg : fill_sum[TOKEN_W-1:0];

    // New request checks
    assign too_big   = q_item.flow > capacity_reg;
    assign req_cover = tokens_reg >= q_item.flow;
    assign req_rem   = tokens_reg - q_item.flow;

    always_comb begin
        capacity_next   = capacity_reg;
        tokens_next     = tokens_reg;
        pend_valid_next = pend_valid_reg;
        pend_flow_next  = pend_flow_reg;
        m_valid_next    = m_valid_reg;
        verdict_next    = verdict_reg;
        left_next       = left_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (take) begin
            if (q_item.mode == MODE_TICK) begin
                if (pend_valid_reg && tick_cover) begin
                    tokens_next     = fill_sat ? cap_rem : sum_rem;
                    pend_valid_next = 1'b0;
                    pend_flow_next  = '0;
                    m_valid_next    = 1'b1;
                    verdict_next    = VERDICT_GRANTED;
                    left_next       = fill_sat ? cap_rem : sum_rem;
                end else begin
                    tokens_next = tick_fill;
                end
            end else begin
                if (too_big) begin
                    m_valid_next = 1'b1;
                    verdict_next = VERDICT_REJECTED;
                    left_next    = tokens_reg;
                end else if (pend_valid_reg) begin
                    m_valid_next = 1'b1;
                    verdict_next = VERDICT_BUSY;
                    left_next    = tokens_reg;
                end else if (req_cover) begin
                    tokens_next  = req_rem;
                    m_valid_next = 1'b1;
                    verdict_next = VERDICT_GRANTED;
                    left_next    = req_rem;
                end else begin
                    pend_valid_next = 1'b1;
                    pend_flow_next  = q_item.flow;
                end
            end
        end

        // Capacity write refills the bucket
        if (cfg_wr_en && cfg_index == CFG_CAPACITY) begin
            capacity_next = cfg_wdata;
            tokens_next   = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= CAPACITY_RESET;
            tokens_reg     <= CAPACITY_RESET;
            pend_valid_reg <= 1'b0;
            pend_flow_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            capacity_reg   <= capacity_next;
            tokens_reg     <= tokens_next;
            pend_valid_reg <= pend_valid_next;
            pend_flow_reg  <= pend_flow_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
        left_reg    <= left_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_verdict     = verdict_reg;
    assign m_tokens_left = left_reg;

endmodule

// ===== src/token_bucket_rate_limiter.sv =====
// Path: a request or tick passes through the front-end pipeline stages and the queue to the
// token engine, which registers its result and holds it until m_ready is seen.
// Throughput: one request per cycle, set by the token update loop, while s_ready is high and results are taken.
// Reset (synchronous, active low): rate and capacity 1000, full bucket, pending slot empty.
// Top level of the token bucket rate limiter.
`timescale 1ns / 1ps

module token_bucket_rate_limiter
    import tbrl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [ELAPSED_W-1:0] s_elapsed_ms,
    input  logic [TOKEN_W-1:0]   s_flow,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VERDICT_W-1:0] m_verdict,
    output logic [TOKEN_W-1:0]   m_tokens_left
);

    logic       q_push, q_pop, q_valid;
    tbrl_item_t push_item, head_item;

    tbrl_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_elapsed_ms (s_elapsed_ms),
        .s_flow       (s_flow),
        .q_pop        (q_pop),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    tbrl_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    tbrl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_tokens_left (m_tokens_left)
    );

endmodule
